@@ rtl/bicubic_hermite_stencil_weights_core_defines.svh @@
// ----------------------------------------------------------------------------
// Stencil weights core assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BICUBIC_HERMITE_STENCIL_WEIGHTS_CORE_DEFINES_SVH
`define BICUBIC_HERMITE_STENCIL_WEIGHTS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset
`define HSW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsw assertion failed");
// Next-cycle implication, sampled on clk, off during reset
`define HSW_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsw assertion failed");
`else
`define HSW_ASSERT_IMP(lbl, ante, cons)
`define HSW_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/hsw_pkg.sv @@
// ----------------------------------------------------------------------------
// Stencil weights package
// Field widths, output limits and register indexes shared by the core.
// ----------------------------------------------------------------------------
package hsw_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int STENCIL_WIDTH = 4;
	localparam int OUT_FRAC      = 16;
	localparam int POS_W         = 32;
	localparam int W_W           = 20;
	localparam int W_MIN         = -524288;
	localparam int W_MAX         = 524287;
	localparam int COL_W         = 2;
	localparam int XIDX_W        = 18;
	localparam int ZC_W          = 16;
	localparam int XFI_W         = 8;
	localparam int XLB_W         = 16;
	localparam int ZS_W          = 17;
	localparam int IN_TDATA_W    = 2 * POS_W;
	localparam int OUT_FIELDS_W  = XIDX_W + ZC_W + STENCIL_WIDTH * W_W;
	localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = ZS_W;

	localparam logic [ZS_W-1:0]  Z_SIZE_MAX = 17'd65536;
	localparam logic [COL_W-1:0] LAST_COL   = COL_W'(STENCIL_WIDTH - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_FIRST_INTERIOR = 2'd0,
		CFG_X_LAST_BOUND     = 2'd1,
		CFG_Z_SIZE           = 2'd2
	} cfg_idx_t;
endpackage

@@ rtl/hsw_zmod.sv @@
// ----------------------------------------------------------------------------
// Z corner wrap
// Pipelined restoring remainder, one dividend bit per stage, then floor fixup.
// ----------------------------------------------------------------------------
module hsw_zmod #(
	parameter int IW = 16,
	parameter int PW = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [IW-1:0]              mag,
	input  logic                       neg,
	input  logic [hsw_pkg::ZS_W-1:0]   modulus,
	input  logic [PW-1:0]              in_pay,
	output logic                       out_valid,
	output logic [hsw_pkg::ZC_W-1:0]   rem,
	output logic [PW-1:0]              out_pay
);
	import hsw_pkg::*;

	logic            valid_s [IW];
	logic [ZS_W-1:0] rem_s   [IW];
	logic [IW-1:0]   mag_s   [IW];
	logic            neg_s   [IW];
	logic [ZS_W-1:0] mod_s   [IW];
	logic [PW-1:0]   pay_s   [IW];
	logic [ZS_W-1:0] rem_fix;

	for (genvar i = 0; i < IW; i++) begin : g_bit
		logic            v_in;
		logic [ZS_W-1:0] r_in;
		logic [IW-1:0]   a_in;
		logic            n_in;
		logic [ZS_W-1:0] m_in;
		logic [PW-1:0]   p_in;
		logic [ZS_W:0]   trial;

		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = '0;
			assign a_in = mag;
			assign n_in = neg;
			assign m_in = modulus;
			assign p_in = in_pay;
		end else begin : g_next
			assign v_in = valid_s[i-1];
			assign r_in = rem_s[i-1];
			assign a_in = mag_s[i-1];
			assign n_in = neg_s[i-1];
			assign m_in = mod_s[i-1];
			assign p_in = pay_s[i-1];
		end

		// bring down the next dividend bit
		assign trial = {r_in, a_in[IW-1-i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= v_in;
			end
		end

		// subtract the modulus where it fits
		always_ff @(posedge clk) begin
			if (en) begin
				if (trial >= {1'b0, m_in}) begin
					rem_s[i] <= ZS_W'(trial - {1'b0, m_in});
				end else begin
					rem_s[i] <= trial[ZS_W-1:0];
				end
				mag_s[i] <= a_in;
				neg_s[i] <= n_in;
				mod_s[i] <= m_in;
				pay_s[i] <= p_in;
			end
		end
	end

	// negative corners wrap from the top of the range
	always_comb begin
		rem_fix = rem_s[IW-1];
		if (neg_s[IW-1] && (rem_s[IW-1] != '0)) begin
			rem_fix = mod_s[IW-1] - rem_s[IW-1];
		end
	end

	assign out_valid = valid_s[IW-1];
	assign rem       = rem_fix[ZC_W-1:0];
	assign out_pay   = pay_s[IW-1];
endmodule

@@ rtl/hsw_coef.sv @@
// ----------------------------------------------------------------------------
// Hermite axis coefficients
// Three stages: t squared, t cubed, then twice the four stencil coefficients.
// ----------------------------------------------------------------------------
module hsw_coef #(
	parameter int FRAC_BITS = 16,
	parameter int PW        = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [FRAC_BITS:0]           tx,
	input  logic [FRAC_BITS:0]           tz,
	input  logic [PW-1:0]                in_pay,
	output logic                         out_valid,
	output logic signed [FRAC_BITS+3:0]  dx [hsw_pkg::STENCIL_WIDTH],
	output logic signed [FRAC_BITS+3:0]  dz [hsw_pkg::STENCIL_WIDTH],
	output logic [PW-1:0]                out_pay
);
	import hsw_pkg::*;

	localparam int TW = FRAC_BITS + 1;
	localparam int DW = FRAC_BITS + 4;
	localparam int EW = FRAC_BITS + 6;
	localparam logic [2*TW-1:0]     HALF = (2*TW)'(1) << (FRAC_BITS - 1);
	localparam logic signed [EW-1:0] ONE = EW'(1) << FRAC_BITS;

	logic [TW-1:0] t_in [2];
	logic          v_s1, v_s2, v_s3;
	logic [PW-1:0] pay_s1, pay_s2, pay_s3;
	logic [TW-1:0] t_s1  [2];
	logic [TW-1:0] t2_s1 [2];
	logic [TW-1:0] t_s2  [2];
	logic [TW-1:0] t2_s2 [2];
	logic [TW-1:0] t3_s2 [2];
	logic signed [DW-1:0] d_s3 [2][STENCIL_WIDTH];

	assign t_in[0] = tx;
	assign t_in[1] = tz;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1 <= in_pay;
			pay_s2 <= pay_s1;
			pay_s3 <= pay_s2;
		end
	end

	for (genvar a = 0; a < 2; a++) begin : g_axis
		logic [2*TW-1:0]       sq;
		logic [2*TW-1:0]       cu;
		logic signed [EW-1:0]  ti, t2i, t3i, h00, h01, h10, h11;

		// round t*t and t^2*t to nearest, ties up
		assign sq  = t_in[a] * t_in[a] + HALF;
		assign cu  = t2_s1[a] * t_s1[a] + HALF;
		assign ti  = EW'(t_s2[a]);
		assign t2i = EW'(t2_s2[a]);
		assign t3i = EW'(t3_s2[a]);
		assign h00 = (t3i <<< 1) - (t2i <<< 1) - t2i + ONE;
		assign h01 = (t2i <<< 1) + t2i - (t3i <<< 1);
		assign h10 = ti - (t2i <<< 1) + t3i;
		assign h11 = t3i - t2i;

		always_ff @(posedge clk) begin
			if (en) begin
				t_s1[a]    <= t_in[a];
				t2_s1[a]   <= sq[FRAC_BITS +: TW];
				t_s2[a]    <= t_s1[a];
				t2_s2[a]   <= t2_s1[a];
				t3_s2[a]   <= cu[FRAC_BITS +: TW];
				d_s3[a][0] <= DW'(-h10);
				d_s3[a][1] <= DW'((h00 <<< 1) - h11);
				d_s3[a][2] <= DW'((h01 <<< 1) + h10);
				d_s3[a][3] <= DW'(h11);
			end
		end
	end

	for (genvar k = 0; k < STENCIL_WIDTH; k++) begin : g_out
		assign dx[k] = d_s3[0][k];
		assign dz[k] = d_s3[1][k];
	end

	assign out_valid = v_s3;
	assign out_pay   = pay_s3;
endmodule

@@ rtl/hsw_serial.sv @@
// ----------------------------------------------------------------------------
// Column serializer
// Holds one item and issues four column beats through a multiply row,
// a round and saturate stage, and the output register.
// ----------------------------------------------------------------------------
`include "bicubic_hermite_stencil_weights_core_defines.svh"

module hsw_serial #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic signed [FRAC_BITS+3:0]      dx [hsw_pkg::STENCIL_WIDTH],
	input  logic signed [FRAC_BITS+3:0]      dz [hsw_pkg::STENCIL_WIDTH],
	input  logic [hsw_pkg::XLB_W-1:0]        xc,
	input  logic [hsw_pkg::ZC_W-1:0]         zc,
	output logic                             h_free,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [hsw_pkg::OUT_TDATA_W-1:0]  out_data,
	output logic [hsw_pkg::COL_W-1:0]        out_col,
	output logic                             out_last
);
	import hsw_pkg::*;

	localparam int DW = FRAC_BITS + 4;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1;
	localparam int SH = 2 * FRAC_BITS + 2 - OUT_FRAC;
	localparam logic signed [SW-1:0] RND  = SW'(1) << (SH - 1);
	localparam logic signed [SW-1:0] RMIN = SW'(W_MIN);
	localparam logic signed [SW-1:0] RMAX = SW'(W_MAX);

	// hold stage
	logic                 v_s1;
	logic [COL_W-1:0]     col_q;
	logic signed [DW-1:0] dx_s1 [STENCIL_WIDTH];
	logic signed [DW-1:0] dz_s1 [STENCIL_WIDTH];
	logic [XLB_W-1:0]     xc_s1;
	logic [ZC_W-1:0]      zc_s1;
	// product stage
	logic                 v_s2;
	logic [COL_W-1:0]     col_s2;
	logic [XIDX_W-1:0]    xidx_s2;
	logic [ZC_W-1:0]      zc_s2;
	logic signed [PW-1:0] prod_s2 [STENCIL_WIDTH];
	// output stage
	logic                 v_s3;
	logic [COL_W-1:0]     col_s3;
	logic [XIDX_W-1:0]    xidx_s3;
	logic [ZC_W-1:0]      zc_s3;
	logic [W_W-1:0]       w_s3 [STENCIL_WIDTH];
	logic                 last_s3;

	logic                 adv_o, adv_p;
	logic signed [SW-1:0] rsum [STENCIL_WIDTH];
	logic signed [SW-1:0] rsh  [STENCIL_WIDTH];
	logic [W_W-1:0]       wsat [STENCIL_WIDTH];

	assign adv_o  = !v_s3 || out_ready;
	assign adv_p  = !v_s2 || adv_o;
	assign h_free = !v_s1 || (adv_p && (col_q == LAST_COL));

	// load a new item or step to the next column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			col_q <= '0;
		end else if (h_free) begin
			v_s1  <= in_valid;
			col_q <= '0;
		end else if (adv_p) begin
			col_q <= col_q + COL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (h_free) begin
			dx_s1 <= dx;
			dz_s1 <= dz;
			xc_s1 <= xc;
			zc_s1 <= zc;
		end
	end

	// multiply the selected x coefficient into the z row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_p) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_p) begin
			col_s2  <= col_q;
			xidx_s2 <= XIDX_W'({2'b00, xc_s1}) - XIDX_W'(1) + XIDX_W'(col_q);
			zc_s2   <= zc_s1;
			for (int k = 0; k < STENCIL_WIDTH; k++) begin
				prod_s2[k] <= dx_s1[col_q] * dz_s1[k];
			end
		end
	end

	// round to nearest, ties up, then clip to the weight range
	always_comb begin
		for (int k = 0; k < STENCIL_WIDTH; k++) begin
			rsum[k] = SW'(prod_s2[k]) + RND;
			rsh[k]  = rsum[k] >>> SH;
			if (rsh[k] < RMIN) begin
				wsat[k] = W_W'(W_MIN);
			end else if (rsh[k] > RMAX) begin
				wsat[k] = W_W'(W_MAX);
			end else begin
				wsat[k] = rsh[k][W_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv_o) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_o) begin
			col_s3  <= col_s2;
			xidx_s3 <= xidx_s2;
			zc_s3   <= zc_s2;
			w_s3    <= wsat;
			last_s3 <= (col_s2 == LAST_COL);
		end
	end

	assign out_valid = v_s3;
	assign out_col   = col_s3;
	assign out_last  = last_s3;
	assign out_data  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), w_s3[3], w_s3[2], w_s3[1], w_s3[0],
		zc_s3, xidx_s3};

	`HSW_ASSERT_IMP(a_last_on_final_col, v_s3, last_s3 == (col_s3 == LAST_COL))
	`HSW_ASSERT_NXT(a_col_steps, v_s3 && out_ready && !last_s3, v_s3 && (col_s3 == $past(col_s3) + 2'd1))
	`HSW_ASSERT_IMP(a_hold_busy, v_s1 && (col_q != LAST_COL), !h_free)
endmodule

@@ rtl/bicubic_hermite_stencil_weights_core.sv @@
// ----------------------------------------------------------------------------
// Bicubic Hermite stencil weights core
// Input beat to first column beat: input register, z remainder stages,
// coefficient stages, then hold, product and output registers; then one
// column beat per cycle while m_axis_tready is high. Each position holds the
// hold stage for four column beats through the single multiply row.
// Reset: arst_n clears all valid bits and restores the register defaults.
// ----------------------------------------------------------------------------
module bicubic_hermite_stencil_weights_core #(
	parameter int FRAC_BITS = hsw_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [hsw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // pos_x, pos_z
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [hsw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // x_index, z_corner,
	                                                         // weight_zm1, weight_z0,
	                                                         // weight_zp1, weight_zp2, pad
	output logic [hsw_pkg::COL_W-1:0]         m_axis_tuser,  // column
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hsw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hsw_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import hsw_pkg::*;

	localparam int IW  = POS_W - FRAC_BITS;
	localparam int CW  = ((IW > ZS_W) ? IW : ZS_W) + 1;
	localparam int TW  = FRAC_BITS + 1;
	localparam int DW  = FRAC_BITS + 4;
	localparam int ZPW = XLB_W + 2 * TW;
	localparam int CPW = XLB_W + ZC_W;

	logic [XFI_W-1:0] x_first_q;
	logic [XLB_W-1:0] x_last_q;
	logic [ZS_W-1:0]  z_size_q;

	logic [POS_W-1:0]     px, pz;
	logic [IW-1:0]        xc_raw, zc_raw, zmag;
	logic signed [CW-1:0] xc_ext, xlb_ext, xfi_ext, xc_cl;
	logic [TW-1:0]        tx, tz;
	logic [ZS_W-1:0]      m_eff;
	logic                 en;
	logic                 h_free_w;

	logic                 v_s1;
	logic [IW-1:0]        zmag_s1;
	logic                 zneg_s1;
	logic [ZS_W-1:0]      m_s1;
	logic [ZPW-1:0]       zpay_s1;

	logic                 zm_valid;
	logic [ZC_W-1:0]      zm_rem;
	logic [ZPW-1:0]       zm_pay;
	logic                 cf_valid;
	logic [CPW-1:0]       cf_pay;
	logic signed [DW-1:0] dx [STENCIL_WIDTH];
	logic signed [DW-1:0] dz [STENCIL_WIDTH];

	// register writes, unused indexes dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_first_q <= XFI_W'(2);
			x_last_q  <= XLB_W'(66);
			z_size_q  <= ZS_W'(64);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_X_FIRST_INTERIOR: x_first_q <= cfg_data[XFI_W-1:0];
				CFG_X_LAST_BOUND:     x_last_q  <= cfg_data[XLB_W-1:0];
				CFG_Z_SIZE:           z_size_q  <= cfg_data[ZS_W-1:0];
				default: ;
			endcase
		end
	end

	// floor both coordinates, clamp x, prepare the z magnitude
	assign px     = s_axis_tdata[POS_W-1:0];
	assign pz     = s_axis_tdata[2*POS_W-1:POS_W];
	assign xc_raw = px[POS_W-1:FRAC_BITS];
	assign zc_raw = pz[POS_W-1:FRAC_BITS];
	assign zmag   = zc_raw[IW-1] ? (~zc_raw + IW'(1)) : zc_raw;
	assign tz     = {1'b0, pz[FRAC_BITS-1:0]};

	always_comb begin
		xc_ext  = {{(CW-IW){xc_raw[IW-1]}}, xc_raw};
		xlb_ext = CW'(x_last_q);
		xfi_ext = CW'(x_first_q);
		xc_cl   = xc_ext;
		tx      = {1'b0, px[FRAC_BITS-1:0]};
		if (xc_ext >= xlb_ext) begin
			xc_cl = xlb_ext - CW'(1);
			tx    = TW'(1) << FRAC_BITS;
		end
		if (xc_cl < xfi_ext) begin
			xc_cl = xfi_ext;
			tx    = '0;
		end
	end

	// zero size acts as one, oversize as the full index range
	always_comb begin
		if (z_size_q == '0) begin
			m_eff = ZS_W'(1);
		end else if (z_size_q > Z_SIZE_MAX) begin
			m_eff = Z_SIZE_MAX;
		end else begin
			m_eff = z_size_q;
		end
	end

	assign en            = h_free_w;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zmag_s1 <= zmag;
			zneg_s1 <= zc_raw[IW-1];
			m_s1    <= m_eff;
			zpay_s1 <= {xc_cl[XLB_W-1:0], tz, tx};
		end
	end

	hsw_zmod #(
		.IW (IW),
		.PW (ZPW)
	) u_zmod (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.mag       (zmag_s1),
		.neg       (zneg_s1),
		.modulus   (m_s1),
		.in_pay    (zpay_s1),
		.out_valid (zm_valid),
		.rem       (zm_rem),
		.out_pay   (zm_pay)
	);

	hsw_coef #(
		.FRAC_BITS (FRAC_BITS),
		.PW        (CPW)
	) u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (zm_valid),
		.tx        (zm_pay[TW-1:0]),
		.tz        (zm_pay[2*TW-1:TW]),
		.in_pay    ({zm_pay[ZPW-1:2*TW], zm_rem}),
		.out_valid (cf_valid),
		.dx        (dx),
		.dz        (dz),
		.out_pay   (cf_pay)
	);

	hsw_serial #(
		.FRAC_BITS (FRAC_BITS)
	) u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cf_valid),
		.dx        (dx),
		.dz        (dz),
		.xc        (cf_pay[CPW-1:ZC_W]),
		.zc        (cf_pay[ZC_W-1:0]),
		.h_free    (h_free_w),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_col   (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);
endmodule
